// ----- rtl/sbmq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbmq_pkg: shared definitions for the shared-buffer multi-queue core
// Status codes, operation codes and the record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package sbmq_pkg;
    localparam int KIND_W   = 1;
    localparam int QID_W    = 2;
    localparam int IO_W     = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        op_t              op;
        logic             qid_ok;
        logic [QID_W-1:0] qid;
        logic [IO_W-1:0]  data;
    } cmd_t;
endpackage
`default_nettype wire

// ----- rtl/sbmq_front.sv -----
// ----------------------------------------------------------------------------
// sbmq_front: command intake and classification
// Accepts input transfers, checks the queue number and holds up to two
// commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sbmq_front
    import sbmq_pkg::*;
#(
    parameter int QUEUES = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [KIND_W-1:0] s_kind,
    input  wire logic [QID_W-1:0] s_queue_id,
    input  wire logic [IO_W-1:0]  s_data_in,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output cmd_t                  cmd
);
    cmd_t       buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb begin
        in_cmd.op     = op_t'(s_kind);
        in_cmd.qid_ok = ({30'd0, s_queue_id} < 32'(QUEUES));
        in_cmd.qid    = s_queue_id;
        in_cmd.data   = s_data_in;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = buf_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !s_ready)
        else $error("front queue accepted while full");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("front queue count out of range");
    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("front queue popped while empty");
`endif
endmodule
`default_nettype wire

// ----- rtl/sbmq_back.sv -----
// ----------------------------------------------------------------------------
// sbmq_back: linked-list execution unit
// Reads the slot link and data in the read state, updates lists in the execute
// state and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module sbmq_back
    import sbmq_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int QUEUES     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  cmd_t                     cmd,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [IO_W-1:0]          m_data_out,
    output logic [STATUS_W-1:0]      m_status
);
    localparam int PW = $clog2(SLOTS + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    logic [PW-1:0]         link_mem [SLOTS];
    logic [DATA_WIDTH-1:0] data_mem [SLOTS];
    logic [PW-1:0]         head_reg [QUEUES];
    logic [PW-1:0]         tail_reg [QUEUES];
    logic [PW-1:0]         free_reg;
    logic [PW-1:0]         fill_reg;   // slots from here up were never allocated
    logic [PW-1:0]         link_rd_reg;
    logic [DATA_WIDTH-1:0] data_rd_reg;
    logic [PW-1:0]         slot_reg;
    logic                  out_valid_reg;
    logic [IO_W-1:0]       out_data_reg;
    status_t               out_status_reg;

    logic [QW-1:0] q;
    logic [PW-1:0] slot, head_q, link_val;
    logic          do_enq, do_deq, fail, exec;

    assign q      = cmd.qid[QW-1:0];
    assign head_q = cmd.qid_ok ? head_reg[q] : NIL;
    assign slot   = (cmd.op == OP_ENQ) ? (cmd.qid_ok ? free_reg : NIL) : head_q;
    assign fail   = (slot >= NIL);
    assign exec   = (state_reg == S_EXEC) && (!out_valid_reg || m_ready);
    assign do_enq = exec && !fail && (cmd.op == OP_ENQ);
    assign do_deq = exec && !fail && (cmd.op == OP_DEQ);
    assign cmd_ready = exec;
    assign link_val  = (link_rd_reg > NIL) ? NIL : link_rd_reg;

    // Slots at or above the fill mark were never allocated, so their link is
    // taken as i+1 instead of being read from the link memory.
    always_ff @(posedge aclk) begin
        if (state_reg == S_READ && !fail) begin
            link_rd_reg <= (slot < fill_reg) ? link_mem[slot[SW-1:0]]
                                             : slot + PW'(1);
            data_rd_reg <= data_mem[slot[SW-1:0]];
            slot_reg    <= slot;
        end
        if (do_enq) begin
            data_mem[slot_reg[SW-1:0]] <= cmd.data[DATA_WIDTH-1:0];
            link_mem[slot_reg[SW-1:0]] <= NIL;
            if (head_reg[q] < NIL && tail_reg[q] < NIL) begin
                link_mem[tail_reg[q][SW-1:0]] <= slot_reg;
            end
        end
        if (do_deq) begin
            link_mem[slot_reg[SW-1:0]] <= free_reg;
        end
        if (exec) begin
            out_data_reg   <= (fail && cmd.op == OP_DEQ) ? IO_W'({DATA_WIDTH{1'b1}})
                            : (cmd.op == OP_DEQ) ? IO_W'(data_rd_reg) : '0;
            out_status_reg <= !fail ? ST_OK
                            : (cmd.op == OP_ENQ) ? ST_OVERFLOW : ST_UNDERFLOW;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_READ;
            out_valid_reg <= 1'b0;
            free_reg      <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end else begin
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_READ: if (cmd_valid) state_reg <= S_EXEC;
                S_EXEC: if (exec) begin
                    state_reg     <= S_READ;
                    out_valid_reg <= 1'b1;
                end
                default: state_reg <= S_READ;
            endcase
            if (do_enq) begin
                free_reg    <= link_val;
                if (head_reg[q] >= NIL) begin
                    head_reg[q] <= slot_reg;
                end
                tail_reg[q] <= slot_reg;
                if (slot_reg == fill_reg) begin
                    fill_reg <= fill_reg + PW'(1);
                end
            end
            if (do_deq) begin
                head_reg[q] <= link_val;
                free_reg    <= slot_reg;
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_data_out = out_data_reg;
    assign m_status   = out_status_reg;

`ifndef SYNTHESIS
    a_exec_slot_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC) && !exec |=> $stable(slot_reg))
        else $error("slot changed while execute stalled");
    a_one_hot_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_hold_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out))
        else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// ----- rtl/shared_buffer_multi_queue_core.sv -----
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_core: several FIFO queues in one slot store
// Queues are linked chains of slots; unused slots form a linked free list.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_kind, s_queue_id, s_data_in
// m_       out        m_valid / m_ready   m_data_out, m_status
//
// In the back end each operation first reads the slot link and data memories,
// then updates the lists and registers the result. The front end holds up to
// two commands, so input transfers can continue while the back end waits on
// m_ready until that buffer is full. Reset (aresetn low, synchronous) empties
// every queue and frees all slots at once through the fill mark; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module shared_buffer_multi_queue_core
    import sbmq_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int QUEUES     = 4,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [KIND_W-1:0]    s_kind,
    input  wire logic [QID_W-1:0]     s_queue_id,
    input  wire logic [IO_W-1:0]      s_data_in,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [IO_W-1:0]           m_data_out,
    output logic [STATUS_W-1:0]       m_status
);
    // Commands between the intake and the execution unit.
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    sbmq_front #(.QUEUES(QUEUES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_queue_id, .s_data_in,
        .cmd_valid, .cmd_ready, .cmd
    );

    sbmq_back #(.SLOTS(SLOTS), .QUEUES(QUEUES), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .m_valid, .m_ready, .m_data_out, .m_status
    );
endmodule
`default_nettype wire
